@@ design/srt_pkg.sv @@
package srt_pkg;

	// Field widths fixed by the event and result formats.
	localparam int Q_W        = 17;
	localparam int IDX_W      = 6;
	localparam int KIND_W     = 2;
	localparam int CNT_OUT_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Lifetime accuracy divider: one quotient bit per step.
	localparam int DIV_STEPS = 17;
	localparam int QUO_W     = 18;
	localparam int STEP_W    = 5;

	// Q1.16 constants and blend weights (0.7 and 0.3 of one).
	localparam logic [Q_W-1:0] ONE_Q16  = 17'h10000;
	localparam logic [15:0]    HALF_Q16 = 16'h8000;
	localparam logic [15:0]    W_RECENT = 16'd45875;
	localparam logic [15:0]    W_LIFE   = 16'd19661;

	// Register values after reset.
	localparam logic [Q_W-1:0]        INIT_TRUST_RST = 17'd32768;
	localparam logic [Q_W-1:0]        EMA_ALPHA_RST  = 17'd6554;
	localparam logic [Q_W-1:0]        FLOOR_RST      = 17'd0;
	localparam logic [Q_W-1:0]        CEIL_RST       = 17'd65536;
	localparam logic [CNT_OUT_W-1:0]  PERIOD_RST     = 32'd10;

	typedef enum logic [KIND_W-1:0] {
		KIND_QUERY     = 2'd0,
		KIND_CORRECT   = 2'd1,
		KIND_INCORRECT = 2'd2,
		KIND_REGISTER  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_TRUST  = 3'd0,
		REG_EMA_ALPHA      = 3'd1,
		REG_TRUST_FLOOR    = 3'd2,
		REG_TRUST_CEILING  = 3'd3,
		REG_CAL_PERIOD     = 3'd4
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic load;
		logic ema;
		logic div_step;
		logic life;
		logic blend;
		logic commit;
	} srt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic outcome;
		logic div_last;
		logic out_free;
	} srt_sts_t;

endpackage

@@ design/srt_req_if.sv @@
interface srt_req_if import srt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [IDX_W-1:0]    source_index;
	logic [Q_W-1:0]      suspicion_threshold;

	modport source(output valid, kind, source_index, suspicion_threshold, input ready);
	modport sink(input valid, kind, source_index, suspicion_threshold, output ready);
endinterface

@@ design/srt_rsp_if.sv @@
interface srt_rsp_if import srt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [Q_W-1:0]        trust_level;
	logic [Q_W-1:0]        recent_accuracy;
	logic [Q_W-1:0]        lifetime_accuracy;
	logic [CNT_OUT_W-1:0]  total_count;
	logic [CNT_OUT_W-1:0]  correct_count;
	logic [CNT_OUT_W-1:0]  incorrect_count;
	logic                  calibrated;
	logic                  known;
	logic                  suspicious;

	modport source(output valid, trust_level, recent_accuracy, lifetime_accuracy, total_count,
		correct_count, incorrect_count, calibrated, known, suspicious, input ready);
	modport sink(input valid, trust_level, recent_accuracy, lifetime_accuracy, total_count,
		correct_count, incorrect_count, calibrated, known, suspicious, output ready);
endinterface

@@ design/srt_ram.sv @@
module srt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/srt_ctrl.sv @@
module srt_ctrl import srt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  srt_sts_t sts,
	output srt_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOAD   = 7'b0000010,
		ST_EMA    = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_LIFE   = 7'b0010000,
		ST_BLEND  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Next state: in-range outcomes run the full update, other events go straight to the answer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = sts.outcome ? ST_EMA : ST_FINISH;
			end
			ST_EMA: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_LIFE;
			end
			ST_LIFE: begin
				state_d = ST_BLEND;
			end
			ST_BLEND: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands decoded from the state.
	assign req_ready    = (state_q == ST_IDLE);
	assign cmd.accept   = (state_q == ST_IDLE) && req_valid;
	assign cmd.load     = (state_q == ST_LOAD);
	assign cmd.ema      = (state_q == ST_EMA);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.life     = (state_q == ST_LIFE);
	assign cmd.blend    = (state_q == ST_BLEND);
	assign cmd.commit   = (state_q == ST_FINISH) && sts.out_free;

	// The result register is only written when it is free.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while result register busy");

	// The lifetime step follows only the last divider step.
	a_div_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_LIFE) |-> $past(sts.div_last))
		else $error("divider left before last step");

endmodule

@@ design/srt_datapath.sv @@
module srt_datapath import srt_pkg::*; #(
	parameter int SOURCE_COUNT = 64,
	parameter int COUNT_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srt_cmd_t              cmd,
	output srt_sts_t              sts,
	input  logic [KIND_W-1:0]     req_kind,
	input  logic [IDX_W-1:0]      req_source_index,
	input  logic [Q_W-1:0]        req_suspicion_threshold,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	srt_rsp_if.source             rsp
);

	localparam int ADDR_W = $clog2(SOURCE_COUNT);
	localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
	localparam int DW     = COUNT_BITS + 1;
	localparam int CMP_W  = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
	localparam bit HALVE_ON_CARRY = (COUNT_BITS == 64);

	typedef struct packed {
		logic [Q_W-1:0]        trust;
		logic [Q_W-1:0]        recent;
		logic [Q_W-1:0]        life;
		logic [COUNT_BITS-1:0] total;
		logic [COUNT_BITS-1:0] correct;
		logic [COUNT_BITS-1:0] incorrect;
		logic                  cal;
	} rec_t;

	function automatic logic [Q_W-1:0] q16_clamp(input logic [Q_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	// Configuration registers.
	logic [Q_W-1:0]       init_trust_q, ema_alpha_q, floor_q, ceil_q;
	logic [CNT_OUT_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_trust_q <= INIT_TRUST_RST;
			ema_alpha_q  <= EMA_ALPHA_RST;
			floor_q      <= FLOOR_RST;
			ceil_q       <= CEIL_RST;
			period_q     <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INITIAL_TRUST: init_trust_q <= cfg_data[Q_W-1:0];
				REG_EMA_ALPHA:     ema_alpha_q  <= cfg_data[Q_W-1:0];
				REG_TRUST_FLOOR:   floor_q      <= cfg_data[Q_W-1:0];
				REG_TRUST_CEILING: ceil_q       <= cfg_data[Q_W-1:0];
				REG_CAL_PERIOD:    period_q     <= cfg_data[CNT_OUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Incoming item address and range check.
	logic [EXT_W-1:0]  idx_ext;
	logic [ADDR_W-1:0] in_addr;
	logic              in_range;

	assign idx_ext  = EXT_W'(req_source_index);
	assign in_addr  = idx_ext[ADDR_W-1:0];
	assign in_range = (32'(req_source_index) < 32'(SOURCE_COUNT));

	kind_t             kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic              in_range_q;
	logic [Q_W-1:0]    thr_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q     <= kind_t'(req_kind);
			addr_q     <= in_addr;
			in_range_q <= in_range;
			thr_q      <= req_suspicion_threshold;
		end
	end

	// Entry store with per-entry valid marks.
	logic [SOURCE_COUNT-1:0] valid_q;
	logic [$bits(rec_t)-1:0] ram_rdata;
	logic                    ram_we;
	rec_t                    rec_q;

	assign ram_we = cmd.commit && in_range_q && (kind_q != KIND_QUERY);

	srt_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(SOURCE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(rec_q),
		.re   (cmd.accept),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	// Load: pick the stored record or a fresh one, and bump the counters for an outcome.
	logic entry_hit, is_outcome, good;
	rec_t base_rec, load_rec;

	assign entry_hit  = in_range_q && valid_q[addr_q];
	assign is_outcome = (kind_q == KIND_CORRECT) || (kind_q == KIND_INCORRECT);
	assign good       = (kind_q == KIND_CORRECT);

	always_comb begin
		if (entry_hit) begin
			base_rec = rec_t'(ram_rdata);
		end else begin
			base_rec.trust     = q16_clamp(init_trust_q);
			base_rec.recent    = q16_clamp(init_trust_q);
			base_rec.life      = '0;
			base_rec.total     = '0;
			base_rec.correct   = '0;
			base_rec.incorrect = '0;
			base_rec.cal       = 1'b0;
		end
		load_rec = base_rec;
		if (is_outcome) begin
			load_rec.total = sat_inc(base_rec.total);
			if (good) begin
				load_rec.correct = sat_inc(base_rec.correct);
			end else begin
				load_rec.incorrect = sat_inc(base_rec.incorrect);
			end
		end
	end

	// Recent accuracy moving average.
	logic [Q_W-1:0] alpha, one_minus, recent_new;
	logic [33:0]    ema_sum;
	logic [17:0]    ema_val;

	assign alpha     = q16_clamp(ema_alpha_q);
	assign one_minus = ONE_Q16 - alpha;
	assign ema_sum   = 34'(rec_q.recent) * 34'(one_minus)
		+ (good ? {1'b0, alpha, 16'b0} : 34'd0) + 34'(HALF_Q16);
	assign ema_val    = ema_sum[33:16];
	assign recent_new = (ema_val > 18'(ONE_Q16)) ? ONE_Q16 : ema_val[Q_W-1:0];

	// Divider setup: denominator is correct plus incorrect, both halved on a carry with 64-bit counters.
	logic [DW-1:0]         sum_full, sum_half, div_d;
	logic [COUNT_BITS-1:0] c_eff;
	logic                  halve, c_ge_d;

	assign sum_full = DW'(rec_q.correct) + DW'(rec_q.incorrect);
	assign sum_half = DW'(rec_q.correct >> 1) + DW'(rec_q.incorrect >> 1);
	assign halve    = HALVE_ON_CARRY && sum_full[DW-1];
	assign div_d    = halve ? sum_half : sum_full;
	assign c_eff    = halve ? (rec_q.correct >> 1) : rec_q.correct;
	assign c_ge_d   = (DW'(c_eff) >= div_d);

	// Divider step: one quotient bit per cycle by compare and subtract.
	logic [DW-1:0]     d_q, rem_q, rem_next;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [DW:0]       two_rem;
	logic              step_ge;

	assign two_rem  = {rem_q, 1'b0};
	assign step_ge  = (two_rem >= {1'b0, d_q});
	assign rem_next = step_ge ? DW'(two_rem - {1'b0, d_q}) : two_rem[DW-1:0];

	// Lifetime accuracy from the quotient, rounded half up.
	logic [QUO_W-1:0] quo_round;
	logic [Q_W-1:0]   life_new;

	assign quo_round = QUO_W'((19'(quo_q) + 19'd1) >> 1);
	assign life_new  = (d_q == '0) ? '0
		: ((quo_round > QUO_W'(ONE_Q16)) ? ONE_Q16 : quo_round[Q_W-1:0]);

	// Trust blend of recent and lifetime accuracy, clamped floor first.
	logic [31:0]    p_recent_q;
	logic [32:0]    blend_sum;
	logic [Q_W-1:0] trust_raw, trust_lo, trust_new, lo_lim, hi_lim;

	assign lo_lim    = q16_clamp(floor_q);
	assign hi_lim    = q16_clamp(ceil_q);
	assign blend_sum = 33'(p_recent_q) + 33'(W_LIFE) * 33'(rec_q.life) + 33'(HALF_Q16);
	assign trust_raw = blend_sum[32:16];
	assign trust_lo  = (trust_raw < lo_lim) ? lo_lim : trust_raw;
	assign trust_new = (trust_lo > hi_lim) ? hi_lim : trust_lo;

	logic known_q;

	// Working record and divider registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rec_q   <= load_rec;
			known_q <= in_range_q && (entry_hit || (kind_q != KIND_QUERY));
		end
		if (cmd.ema) begin
			rec_q.recent <= recent_new;
			rec_q.cal    <= rec_q.cal || (CMP_W'(rec_q.total) >= CMP_W'(period_q));
			d_q          <= div_d;
			rem_q        <= c_ge_d ? '0 : DW'(c_eff);
			quo_q        <= c_ge_d ? QUO_W'(1) : '0;
			step_q       <= '0;
		end
		if (cmd.div_step) begin
			rem_q      <= rem_next;
			quo_q      <= {quo_q[QUO_W-2:0], step_ge};
			step_q     <= step_q + STEP_W'(1);
			p_recent_q <= 32'(W_RECENT) * 32'(rec_q.recent);
		end
		if (cmd.life) begin
			rec_q.life <= life_new;
		end
		if (cmd.blend) begin
			rec_q.trust <= trust_new;
		end
	end

	// Result register.
	logic                 out_valid_q;
	logic [Q_W-1:0]       out_trust_q, out_recent_q, out_life_q;
	logic [CNT_OUT_W-1:0] out_total_q, out_correct_q, out_incorrect_q;
	logic                 out_cal_q, out_known_q, out_susp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_known_q <= known_q;
			if (known_q) begin
				out_trust_q     <= rec_q.trust;
				out_recent_q    <= rec_q.recent;
				out_life_q      <= rec_q.life;
				out_total_q     <= CNT_OUT_W'(rec_q.total);
				out_correct_q   <= CNT_OUT_W'(rec_q.correct);
				out_incorrect_q <= CNT_OUT_W'(rec_q.incorrect);
				out_cal_q       <= rec_q.cal;
				out_susp_q      <= rec_q.cal && (rec_q.trust < thr_q);
			end else begin
				out_trust_q     <= q16_clamp(init_trust_q);
				out_recent_q    <= '0;
				out_life_q      <= '0;
				out_total_q     <= '0;
				out_correct_q   <= '0;
				out_incorrect_q <= '0;
				out_cal_q       <= 1'b0;
				out_susp_q      <= 1'b0;
			end
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.trust_level       = out_trust_q;
	assign rsp.recent_accuracy   = out_recent_q;
	assign rsp.lifetime_accuracy = out_life_q;
	assign rsp.total_count       = out_total_q;
	assign rsp.correct_count     = out_correct_q;
	assign rsp.incorrect_count   = out_incorrect_q;
	assign rsp.calibrated        = out_cal_q;
	assign rsp.known             = out_known_q;
	assign rsp.suspicious        = out_susp_q;

	// Status to the controller.
	assign sts.outcome  = in_range_q && is_outcome;
	assign sts.div_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_valid_q || rsp.ready;

	// A written entry is marked valid right after.
	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(addr_q)])
		else $error("entry written but not marked valid");

	// Suspicious is only reported for known, calibrated sources.
	a_susp_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_susp_q || (out_cal_q && out_known_q)))
		else $error("suspicious flag without known calibrated entry");

	// Committed Q1.16 values never exceed one.
	a_q16_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ((rec_q.trust <= ONE_Q16) && (rec_q.recent <= ONE_Q16)
			&& (rec_q.life <= ONE_Q16)))
		else $error("Q1.16 field out of range at commit");

endmodule

@@ design/source_reliability_tracker_core.sv @@
// Source reliability tracker. Each request item names a source and an event kind
// (query, correct outcome, incorrect outcome, register); every item returns exactly
// one result item with the entry's trust, recent and lifetime accuracy, saturating
// counters, and the calibrated, known and suspicious flags. An unknown source answers
// with the initial trust and zeros. Items are handled one at a time: a query or register
// event goes from the entry RAM read through load to the finish state; an outcome also
// runs the moving average, the 17-step compare-and-subtract divider for lifetime accuracy
// and the blend multiplies before the write-back in the finish state. A result that is
// not taken holds the finish state until the result register frees; the next item can
// be accepted while a finished result waits. Valid marks clear at reset with no clearing
// pass. Configuration writes must be made while the block is idle.
module source_reliability_tracker_core import srt_pkg::*; #(
	parameter int SOURCE_COUNT = 64,
	parameter int COUNT_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	srt_req_if.sink               req,
	srt_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	srt_cmd_t cmd;
	srt_sts_t sts;
	logic     ready;

	assign req.ready = ready;

	// Sequencer for the update steps.
	srt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Entry store, arithmetic and result register.
	srt_datapath #(
		.SOURCE_COUNT(SOURCE_COUNT),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.req_kind               (req.kind),
		.req_source_index       (req.source_index),
		.req_suspicion_threshold(req.suspicion_threshold),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.rsp                    (rsp)
	);

endmodule

@@ test/testbench.sv @@
module testbench;
	import srt_pkg::*;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 240;
	localparam int IDLE_PCT = 21;
	localparam int COLD_FIRST = 60;
	localparam int SETTLE_CYCLES = 30;
	localparam int CYCLE_LIMIT = 500000;
	localparam longint unsigned COUNT_SAT = 64'hFFFF_FFFF;
	localparam logic [Q_W-1:0] THR_MAX = 17'h1FFFF;

	// One result item as the block reports it.
	typedef struct packed {
		logic [Q_W-1:0]       trust;
		logic [Q_W-1:0]       recent;
		logic [Q_W-1:0]       lifetime;
		logic [CNT_OUT_W-1:0] total;
		logic [CNT_OUT_W-1:0] correct;
		logic [CNT_OUT_W-1:0] incorrect;
		logic                 calibrated;
		logic                 known;
		logic                 suspicious;
	} trust_rec_t;

	// One directed event, with the answer typed in where it is obvious.
	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] src;
		logic [Q_W-1:0]   thr;
		logic             typed;
		trust_rec_t       rec;
	} event_row_t;

	localparam trust_rec_t UNKNOWN_AT_RESET =
		'{17'd32768, 17'd0, 17'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0};
	localparam trust_rec_t FRESH_AT_RESET =
		'{17'd32768, 17'd32768, 17'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0};

	// Directed events, all under the reset register values.
	localparam event_row_t DIRECTED [24] = '{
		'{KIND_QUERY,     6'd0,  17'd0,      1'b1, UNKNOWN_AT_RESET},
		'{KIND_QUERY,     6'd63, THR_MAX,    1'b1, UNKNOWN_AT_RESET},
		'{KIND_REGISTER,  6'd0,  17'd0,      1'b1, FRESH_AT_RESET},
		'{KIND_REGISTER,  6'd0,  THR_MAX,    1'b1, FRESH_AT_RESET},
		'{KIND_QUERY,     6'd0,  17'h10000,  1'b1, FRESH_AT_RESET},
		'{KIND_CORRECT,   6'd63, 17'd0,      1'b0, '0},
		'{KIND_INCORRECT, 6'd62, THR_MAX,    1'b0, '0},
		'{KIND_CORRECT,   6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_CORRECT,   6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_CORRECT,   6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd5,  17'd0,      1'b0, '0},
		'{KIND_CORRECT,   6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_CORRECT,   6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_CORRECT,   6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_QUERY,     6'd5,  17'd0,      1'b0, '0},
		'{KIND_QUERY,     6'd5,  17'h10000,  1'b0, '0},
		'{KIND_REGISTER,  6'd5,  THR_MAX,    1'b0, '0},
		'{KIND_INCORRECT, 6'd0,  THR_MAX,    1'b0, '0},
		'{KIND_QUERY,     6'd62, 17'd1,      1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	srt_req_if req_ch ();
	srt_rsp_if rsp_ch ();

	source_reliability_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the trust table and of the registers.
	bit                src_known [64];
	logic [Q_W-1:0]    src_trust [64];
	logic [Q_W-1:0]    src_recent [64];
	logic [Q_W-1:0]    src_life [64];
	longint unsigned   src_total [64];
	longint unsigned   src_good [64];
	longint unsigned   src_bad [64];
	bit                src_cal [64];
	logic [Q_W-1:0]    cfg_init, cfg_alpha, cfg_floor, cfg_ceil;
	logic [31:0]       cfg_period;

	trust_rec_t expected_results [$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_on = 1'b1;

	function automatic logic [Q_W-1:0] sat_one(logic [Q_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic longint unsigned bump(longint unsigned v);
		return (v >= COUNT_SAT) ? COUNT_SAT : v + 1;
	endfunction

	// Apply one event to the shadow table and return the answer it earns.
	function automatic trust_rec_t predict_event(kind_t k, logic [IDX_W-1:0] s,
			logic [Q_W-1:0] thr);
		trust_rec_t r;
		longint unsigned a, rec, life, blend, denom;
		r = '0;
		if (k != KIND_QUERY && !src_known[s]) begin
			src_known[s] = 1'b1;
			src_trust[s] = sat_one(cfg_init);
			src_recent[s] = sat_one(cfg_init);
			src_life[s] = '0;
			src_total[s] = 0;
			src_good[s] = 0;
			src_bad[s] = 0;
			src_cal[s] = 1'b0;
		end
		if (k == KIND_CORRECT || k == KIND_INCORRECT) begin
			a = 64'(sat_one(cfg_alpha));
			src_total[s] = bump(src_total[s]);
			if (k == KIND_CORRECT)
				src_good[s] = bump(src_good[s]);
			else
				src_bad[s] = bump(src_bad[s]);
			// Moving average with the newest outcome weighted by alpha.
			rec = 64'(src_recent[s]);
			rec = (rec * (65536 - a) + ((k == KIND_CORRECT) ? a * 65536 : 0) + 32768) >> 16;
			if (rec > 65536)
				rec = 65536;
			src_recent[s] = Q_W'(rec);
			// Lifetime ratio rounded to nearest, ties up.
			denom = src_good[s] + src_bad[s];
			life = (denom == 0) ? 0 : (((src_good[s] << 17) / denom) + 1) >> 1;
			if (life > 65536)
				life = 65536;
			src_life[s] = Q_W'(life);
			// Blend, then floor, then ceiling; the ceiling wins a conflict.
			blend = (64'd45875 * rec + 64'd19661 * life + 32768) >> 16;
			if (blend < sat_one(cfg_floor))
				blend = 64'(sat_one(cfg_floor));
			if (blend > sat_one(cfg_ceil))
				blend = 64'(sat_one(cfg_ceil));
			src_trust[s] = Q_W'(blend);
			if (src_total[s] >= cfg_period)
				src_cal[s] = 1'b1;
		end
		if (!src_known[s]) begin
			r.trust = sat_one(cfg_init);
			return r;
		end
		r.trust = src_trust[s];
		r.recent = src_recent[s];
		r.lifetime = src_life[s];
		r.total = CNT_OUT_W'(src_total[s]);
		r.correct = CNT_OUT_W'(src_good[s]);
		r.incorrect = CNT_OUT_W'(src_bad[s]);
		r.calibrated = src_cal[s];
		r.known = 1'b1;
		r.suspicious = src_cal[s] && (src_trust[s] < thr);
		return r;
	endfunction

	// Offer one item, wait for its acceptance, and queue its answer.
	task automatic send_event(kind_t k, logic [IDX_W-1:0] s, logic [Q_W-1:0] thr,
			logic typed, trust_rec_t typed_rec);
		trust_rec_t predicted;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.source_index <= s;
		req_ch.suspicion_threshold <= thr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = predict_event(k, s, thr);
		expected_results.insert(expected_results.size(), typed ? typed_rec : predicted);
	endtask

	// Hold off the sender until every answer is back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		case (r)
			REG_INITIAL_TRUST: cfg_init = v[Q_W-1:0];
			REG_EMA_ALPHA:     cfg_alpha = v[Q_W-1:0];
			REG_TRUST_FLOOR:   cfg_floor = v[Q_W-1:0];
			REG_TRUST_CEILING: cfg_ceil = v[Q_W-1:0];
			REG_CAL_PERIOD:    cfg_period = v;
			default: ;
		endcase
	endtask

	// Reprogram every register once the block has gone quiet.
	task automatic set_registers(logic [31:0] init, logic [31:0] alpha, logic [31:0] lo,
			logic [31:0] hi, logic [31:0] period);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_INITIAL_TRUST, init);
		write_reg(REG_EMA_ALPHA, alpha);
		write_reg(REG_TRUST_FLOOR, lo);
		write_reg(REG_TRUST_CEILING, hi);
		write_reg(REG_CAL_PERIOD, period);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_q_reg();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'h10000;
			2: return $urandom;
			default: return $urandom_range(65536);
		endcase
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result item with nothing expected", $time);
			end else begin
				check_field("trust_level", expected_results[0].trust, rsp_ch.trust_level);
				check_field("recent_accuracy", expected_results[0].recent,
					rsp_ch.recent_accuracy);
				check_field("lifetime_accuracy", expected_results[0].lifetime,
					rsp_ch.lifetime_accuracy);
				check_field("total_count", expected_results[0].total, rsp_ch.total_count);
				check_field("correct_count", expected_results[0].correct,
					rsp_ch.correct_count);
				check_field("incorrect_count", expected_results[0].incorrect,
					rsp_ch.incorrect_count);
				check_field("calibrated", expected_results[0].calibrated, rsp_ch.calibrated);
				check_field("known", expected_results[0].known, rsp_ch.known);
				check_field("suspicious", expected_results[0].suspicious, rsp_ch.suspicious);
				void'(expected_results.pop_front());
			end
		end
	end

	// Result side back-pressure.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time,
				expected_results.size());
			$display("source_reliability_tracker_core regression: fail");
			$finish;
		end
	end

	initial begin
		kind_t k;
		logic [IDX_W-1:0] s;
		logic [Q_W-1:0] thr;
		int hot_base, good_pct, roll;
		bit last;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INITIAL_TRUST;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_QUERY;
		req_ch.source_index = '0;
		req_ch.suspicion_threshold = '0;
		cfg_init = INIT_TRUST_RST;
		cfg_alpha = EMA_ALPHA_RST;
		cfg_floor = FLOOR_RST;
		cfg_ceil = CEIL_RST;
		cfg_period = PERIOD_RST;
		for (int i = 0; i < 64; i++) begin
			src_known[i] = 1'b0;
			src_cal[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events under the reset register values.
		foreach (DIRECTED[i])
			send_event(DIRECTED[i].kind, DIRECTED[i].src, DIRECTED[i].thr,
				DIRECTED[i].typed, DIRECTED[i].rec);

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				// Floor above ceiling, zero period, full alpha, zero initial trust.
				0: set_registers(32'd0, 32'h10000, 32'd40000, 32'd30000, 32'd0);
				// Out-of-range initial trust and ceiling, alpha zero, period one.
				1: set_registers(32'h1FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
				// Pinned trust and a period that is never reached.
				2: set_registers(32'h10000, 32'h1FFFF, 32'h10000, 32'h10000, 32'hFFFF_FFFF);
				default: set_registers(pick_q_reg(), pick_q_reg(), pick_q_reg(), pick_q_reg(),
					($urandom_range(9) == 0) ? $urandom : $urandom_range(40));
			endcase
			last = (p == PHASES - 1);
			idle_on = (p != 4);
			hot_base = last ? 58 : (p * 7) % COLD_FIRST;
			good_pct = $urandom_range(10, 90);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					drain_results();
				// Mostly outcome runs on a few hot sources; some stray items, queries but in the last phase.
				if ($urandom_range(9) == 0) begin
					s = IDX_W'($urandom_range(63));
					k = last ? kind_t'($urandom_range(3)) : KIND_QUERY;
				end else begin
					s = IDX_W'((hot_base + $urandom_range(5)) % (last ? 64 : COLD_FIRST));
					roll = $urandom_range(99);
					if (roll < 15)
						k = KIND_QUERY;
					else if (roll < 25)
						k = KIND_REGISTER;
					else if (roll < 25 + good_pct * 75 / 100)
						k = KIND_CORRECT;
					else
						k = KIND_INCORRECT;
				end
				roll = $urandom_range(9);
				if (roll == 0)
					thr = '0;
				else if (roll == 1)
					thr = THR_MAX;
				else if (roll < 4)
					thr = Q_W'($urandom);
				else
					thr = Q_W'($urandom_range(65536));
				send_event(k, s, thr, 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
		end
		if (mismatches == 0)
			$display("source_reliability_tracker_core regression: pass");
		else
			$display("source_reliability_tracker_core regression: fail");
		$finish;
	end

endmodule
